### hdl/bsfr_pkg.sv
// Shared types and constants for the byte-stuffed frame receiver.
// Used by bsfr_parse and byte_stuffed_frame_receiver; depends on nothing.
package bsfr_pkg;

  localparam int unsigned DEFAULT_MAX_FRAME_BYTES = 512;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned CIDX_W = 8;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_START_CODE  = 8'd0;
  localparam logic [CIDX_W-1:0] CFG_END_CODE    = 8'd1;
  localparam logic [CIDX_W-1:0] CFG_ESCAPE_CODE = 8'd2;
  localparam logic [CIDX_W-1:0] CFG_ESCAPE_MASK = 8'd3;

  localparam logic [BYTE_W-1:0] RST_START_CODE  = 8'd247;
  localparam logic [BYTE_W-1:0] RST_END_CODE    = 8'd127;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE = 8'd246;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_MASK = 8'd32;

  typedef enum logic [STAT_W-1:0] {
    ST_PAYLOAD  = 3'd0,
    ST_GOOD     = 3'd1,
    ST_BAD      = 3'd2,
    ST_SHORT    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] end_code;
    logic [BYTE_W-1:0] escape_code;
    logic [BYTE_W-1:0] escape_mask;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    status_t           status;
    logic [LEN_W-1:0]  len;
  } result_t;

endpackage

### hdl/bsfr_parse.sv
// Frame parser: start/escape/end decoding, two-byte hold, mod-256 Fletcher-style sums.
// Holds the per-frame state; depends on bsfr_pkg.
module bsfr_parse #(
  parameter int unsigned MAX_FRAME_BYTES = bsfr_pkg::DEFAULT_MAX_FRAME_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic [bsfr_pkg::BYTE_W-1:0]   rx_byte,
  input  bsfr_pkg::cfg_t                cfg,
  output bsfr_pkg::result_t             res
);
  import bsfr_pkg::*;

  localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned XW = (CW > LEN_W) ? CW : LEN_W;
  localparam int unsigned OVF_LEN_I =
    (MAX_FRAME_BYTES - 2 > 511) ? 511 : MAX_FRAME_BYTES - 2;
  localparam logic [LEN_W-1:0] OVF_LEN = LEN_W'(OVF_LEN_I);
  localparam logic [CW-1:0]    CNT_MAX = CW'(MAX_FRAME_BYTES);

  typedef enum logic [1:0] {
    MODE_WAIT     = 2'd0,
    MODE_VERBATIM = 2'd1,
    MODE_ESCAPED  = 2'd2
  } mode_t;

  mode_t             mode_r, mode_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] older_r, older_nxt;
  logic [BYTE_W-1:0] newer_r, newer_nxt;
  logic [BYTE_W-1:0] sum_lo_r, sum_lo_nxt;
  logic [BYTE_W-1:0] sum_hi_r, sum_hi_nxt;

  logic [BYTE_W-1:0] store_val;
  logic              do_store;
  logic [CW-1:0]     cnt_inc;
  logic [XW-1:0]     cnt_x;
  logic [XW-1:0]     len_diff;
  logic [LEN_W-1:0]  close_len;
  logic [BYTE_W-1:0] lo_acc;

  always_comb begin
    cnt_x     = XW'(cnt_r);
    len_diff  = cnt_x - XW'(2);
    close_len = (len_diff > XW'(LEN_MAX)) ? LEN_MAX : len_diff[LEN_W-1:0];
    cnt_inc   = cnt_r + CW'(1);
    lo_acc    = sum_lo_r + older_r;

    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    older_nxt  = older_r;
    newer_nxt  = newer_r;
    sum_lo_nxt = sum_lo_r;
    sum_hi_nxt = sum_hi_r;
    do_store   = 1'b0;
    store_val  = rx_byte;

    res        = '0;
    res.status = ST_PAYLOAD;

    case (mode_r)
      MODE_WAIT: begin
        if (rx_byte == cfg.start_code) begin
          mode_nxt = MODE_VERBATIM;
        end
      end
      MODE_ESCAPED: begin
        mode_nxt  = MODE_VERBATIM;
        store_val = rx_byte ^ cfg.escape_mask;
        do_store  = 1'b1;
      end
      MODE_VERBATIM: begin
        if (rx_byte == cfg.escape_code) begin
          mode_nxt = MODE_ESCAPED;
        end else if (rx_byte == cfg.end_code) begin
          res.valid = 1'b1;
          if (cnt_r < CW'(2)) begin
            res.status = ST_SHORT;
          end else begin
            res.status = (older_r == sum_lo_r && newer_r == sum_hi_r) ? ST_GOOD : ST_BAD;
            res.len    = close_len;
          end
          // close: back to the reset state
          mode_nxt   = MODE_WAIT;
          cnt_nxt    = '0;
          older_nxt  = '0;
          newer_nxt  = '0;
          sum_lo_nxt = '0;
          sum_hi_nxt = '0;
        end else begin
          do_store = 1'b1;
        end
      end
      default: begin
        mode_nxt = MODE_WAIT;
      end
    endcase

    if (do_store) begin
      if (cnt_inc == CNT_MAX) begin
        // frame full: drop it
        res.valid  = 1'b1;
        res.status = ST_OVERFLOW;
        res.len    = OVF_LEN;
        mode_nxt   = MODE_WAIT;
        cnt_nxt    = '0;
        older_nxt  = '0;
        newer_nxt  = '0;
        sum_lo_nxt = '0;
        sum_hi_nxt = '0;
      end else begin
        older_nxt = newer_r;
        newer_nxt = store_val;
        cnt_nxt   = cnt_inc;
        if (cnt_r >= CW'(2)) begin
          res.valid  = 1'b1;
          res.data   = older_r;
          sum_lo_nxt = lo_acc;
          sum_hi_nxt = sum_hi_r + lo_acc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_WAIT;
      cnt_r    <= '0;
      older_r  <= '0;
      newer_r  <= '0;
      sum_lo_r <= '0;
      sum_hi_r <= '0;
    end else if (step_en) begin
      mode_r   <= mode_nxt;
      cnt_r    <= cnt_nxt;
      older_r  <= older_nxt;
      newer_r  <= newer_nxt;
      sum_lo_r <= sum_lo_nxt;
      sum_hi_r <= sum_hi_nxt;
    end
  end

endmodule

### hdl/byte_stuffed_frame_receiver.sv
// Top level of the byte-stuffed frame receiver: input register, parser,
// result register and configuration registers. Depends on bsfr_pkg, bsfr_parse.
//
// Takes one raw byte per clock when not stalled and returns at most one result
// per byte. A byte accepted into the input register is decoded by the parser
// in a single pass, which loads the result register once it is free. Sustained
// rate is one byte per cycle; the input stalls only while the result register
// holds an untaken result and the input register is full. Payload bytes come out
// two stored bytes late (the trailing two are the mod-256 Fletcher-style
// checksum, low byte sum1, high byte sum2). A frame closes with status good,
// checksum bad, too short or, when storing a byte would make MAX_FRAME_BYTES
// stored bytes, overflow. The configuration port is always ready; write it only
// while the block is idle.
module byte_stuffed_frame_receiver #(
  parameter int unsigned MAX_FRAME_BYTES = bsfr_pkg::DEFAULT_MAX_FRAME_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bsfr_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bsfr_pkg::BYTE_W-1:0]   out_byte,
  output logic [bsfr_pkg::STAT_W-1:0]   out_status,
  output logic [bsfr_pkg::LEN_W-1:0]    out_frame_length,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsfr_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bsfr_pkg::BYTE_W-1:0]   cfg_data
);
  import bsfr_pkg::*;

  cfg_t              cfg_r;
  logic              s1_vld_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              adv;
  logic              out_free;
  result_t           res;
  result_t           out_r;

  assign out_free  = !out_r.valid || !out_stall;
  assign adv       = s1_vld_r && out_free;
  assign in_stall  = s1_vld_r && !out_free;
  assign cfg_ready = 1'b1;

  bsfr_parse #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .rx_byte (s1_byte_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (out_free) begin
      out_r.valid <= adv && res.valid;
    end
    if (adv && out_free) begin
      out_r.data   <= res.data;
      out_r.status <= res.status;
      out_r.len    <= res.len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code  <= RST_START_CODE;
      cfg_r.end_code    <= RST_END_CODE;
      cfg_r.escape_code <= RST_ESCAPE_CODE;
      cfg_r.escape_mask <= RST_ESCAPE_MASK;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_CODE:  cfg_r.start_code  <= cfg_data;
        CFG_END_CODE:    cfg_r.end_code    <= cfg_data;
        CFG_ESCAPE_CODE: cfg_r.escape_code <= cfg_data;
        CFG_ESCAPE_MASK: cfg_r.escape_mask <= cfg_data;
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  assign out_valid        = out_r.valid;
  assign out_byte         = out_r.data;
  assign out_status       = out_r.status;
  assign out_frame_length = out_r.len;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with an empty input register");

  a_payload_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_PAYLOAD) |-> out_frame_length == '0)
    else $error("payload result carries a frame length");

  a_close_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_PAYLOAD) |-> out_byte == '0)
    else $error("closing result carries a data byte");

  a_no_result_without_item: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !s1_vld_r) |=> !out_valid)
    else $error("result appeared without an accepted byte");

endmodule
